[rtl/ktst_pkg.sv]
package ktst_pkg;

   // width of a stored key
   localparam int unsigned KEY_W = 32;

   // action codes
   localparam logic ACT_QUERY  = 1'b0;
   localparam logic ACT_TOGGLE = 1'b1;

   typedef struct packed {
      logic             action;
      logic [KEY_W-1:0] key;
      logic             expanded;
   } req_type;

   typedef struct packed {
      logic absent;
      logic overflow;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;     // latch request
      logic scan_init;   // pointer to slot zero
      logic scan_run;    // upward scan, one read per cycle
      logic trim_run;    // downward scan over trailing holes
      logic wr_pos;      // write at found slot
      logic wr_zero;     // write data is zero instead of key
      logic wr_top;      // append key at top
      logic top_to_pos;  // top drops to found slot
      logic finish;      // issue result beat
      logic absent;
      logic overflow;
   } ctl_type;

   // status from datapath to controller
   typedef struct packed {
      logic action;
      logic expanded;
      logic hit;
      logic miss;
      logic full;
      logic pos_last;
      logic pos_zero;
      logic trim_done;
   } sts_type;

endpackage

[rtl/ktst_ctrl.sv]
module ktst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ktst_pkg::sts_type sts,
   output ktst_pkg::ctl_type ctl
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_WR_POS = 5'b00100,
      ST_WR_TOP = 5'b01000,
      ST_TRIM   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.capture   = 1'b1;
               ctl.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.scan_run = 1'b1;
            if (sts.action == ktst_pkg::ACT_QUERY) begin
               if (sts.hit || sts.miss) begin
                  ctl.finish = 1'b1;
                  ctl.absent = !sts.hit;
                  state_in   = ST_IDLE;
               end
            end else if (sts.hit) begin
               state_in = ST_WR_POS;
            end else if (sts.miss) begin
               if (sts.expanded) begin
                  ctl.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else if (sts.full) begin
                  ctl.finish   = 1'b1;
                  ctl.overflow = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_WR_TOP;
               end
            end
         end
         ST_WR_POS: begin
            ctl.wr_pos  = 1'b1;
            ctl.wr_zero = sts.expanded;
            if (sts.expanded && sts.pos_last) begin
               ctl.top_to_pos = 1'b1;
               if (sts.pos_zero) begin
                  ctl.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_TRIM;
               end
            end else begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_WR_TOP: begin
            ctl.wr_top = 1'b1;
            ctl.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_TRIM: begin
            ctl.trim_run = 1'b1;
            if (sts.trim_done) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/ktst_datapath.sv]
module ktst_datapath #(
   parameter int unsigned SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  ktst_pkg::req_type req_item,
   input  ktst_pkg::ctl_type ctl,
   output ktst_pkg::sts_type sts,
   output logic              rsp_strobe,
   output ktst_pkg::rsp_type rsp_item
);

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned CNT_W = $clog2(SLOTS + 1);
   localparam int unsigned KEY_W = ktst_pkg::KEY_W;

   logic [KEY_W-1:0] slot_mem [SLOTS];

   ktst_pkg::req_type req_ff;
   logic [CNT_W-1:0]  top_ff, top_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [KEY_W-1:0]  rd_data_ff;
   logic              rsp_valid_ff;
   ktst_pkg::rsp_type rsp_ff;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [KEY_W-1:0]  wr_data;
   logic [KEY_W-1:0]  target;
   logic [CNT_W-1:0]  ptr_dec;
   logic              rd_zero;

   // inserts hunt for a hole, everything else for the key itself
   assign target  = (req_ff.action == ktst_pkg::ACT_TOGGLE && !req_ff.expanded)
                    ? '0 : req_ff.key;
   assign ptr_dec = ptr_ff - CNT_W'(1);
   assign rd_zero = (rd_data_ff == '0);

   assign sts.action    = req_ff.action;
   assign sts.expanded  = req_ff.expanded;
   assign sts.hit       = rd_valid_ff && (rd_data_ff == target);
   assign sts.miss      = !rd_valid_ff && (ptr_ff >= top_ff);
   assign sts.full      = (top_ff == CNT_W'(SLOTS));
   assign sts.pos_last  = ((CNT_W'(pos_ff) + CNT_W'(1)) == top_ff);
   assign sts.pos_zero  = (pos_ff == '0);
   assign sts.trim_done = rd_valid_ff && (!rd_zero || rd_idx_ff == '0);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ptr_ff[IDX_W-1:0];
      ptr_in  = ptr_ff;
      pos_in  = pos_ff;
      top_in  = top_ff;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = ctl.wr_zero ? '0 : req_ff.key;
      if (ctl.scan_init) begin
         ptr_in = '0;
      end
      if (ctl.scan_run) begin
         if (ptr_ff < top_ff) begin
            rd_en  = 1'b1;
            ptr_in = ptr_ff + CNT_W'(1);
         end
         if (sts.hit) begin
            pos_in = rd_idx_ff;
         end
      end
      if (ctl.trim_run) begin
         if (ptr_ff != '0) begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec[IDX_W-1:0];
            ptr_in  = ptr_dec;
         end
         if (rd_valid_ff && rd_zero) begin
            top_in = CNT_W'(rd_idx_ff);
         end
      end
      if (ctl.wr_pos) begin
         wr_en = 1'b1;
      end
      if (ctl.top_to_pos) begin
         top_in = CNT_W'(pos_ff);
         ptr_in = CNT_W'(pos_ff);
      end
      if (ctl.wr_top) begin
         wr_en   = 1'b1;
         wr_addr = top_ff[IDX_W-1:0];
         wr_data = req_ff.key;
         top_in  = top_ff + CNT_W'(1);
      end
   end

   assign rd_valid_in = rd_en;

   // single-port slot store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req_item;
      end
      if (rd_en) begin
         rd_idx_ff <= rd_addr;
      end
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      if (ctl.finish) begin
         rsp_ff.absent   <= ctl.absent;
         rsp_ff.overflow <= ctl.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff       <= top_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= ctl.finish;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

[rtl/key_toggle_set_table_unit.sv]
// Set of 32-bit keys held in SLOTS slots below a top count; a slot holding
// zero is a hole. A request is taken when start is high and busy is low, and
// busy stays high until its result beat has been decided. Each request gives
// exactly one result beat on rsp_strobe/rsp_item, one cycle wide, in the
// same cycle that busy drops; the receiver cannot stall it, so it must take
// every beat. A request walks the slots in use through the single slot
// memory port, one slot per cycle with a registered read: a query or a
// removal that misses scans every slot below top, a hit at slot p stops
// there, and an insert stops at the first hole or else appends at top. A
// removal that empties the top slot then walks down over the trailing
// holes, one slot per cycle. Slot contents are not cleared at reset; only
// slots below top are ever read.
module key_toggle_set_table_unit #(
   parameter int unsigned SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ktst_pkg::req_type req_item,
   output logic              rsp_strobe,
   output ktst_pkg::rsp_type rsp_item
);

   // command and status between sequencer and slot datapath
   ktst_pkg::ctl_type ctl;
   ktst_pkg::sts_type sts;

   // sequencer: scan, write, trim, finish
   ktst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   // slot memory, top count, scan pointer and result register
   ktst_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

[rtl/ktst_checker.sv]
module ktst_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input ktst_pkg::rsp_type rsp_item
);

   // taking a request makes the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but unit not busy");

   // every end of work gives a result beat
   a_done_beat: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("work ended without result beat");

   // a result beat is only shown while idle
   a_beat_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // beats never come back to back
   a_beat_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result beats in a row");

   // a result never flags both outcomes
   a_beat_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_item.absent && rsp_item.overflow))
      else $error("absent and overflow both set");

endmodule

bind key_toggle_set_table_unit ktst_checker u_ktst_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
